FILE: rtl/core/ssid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_pkg: shared types and constants for the sorted set block
// Capacity, derived widths, operation and status codes, control command.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int OP_W     = 2;
  localparam int VAL_W    = 32;
  localparam int RANK_W   = 4;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_OK        = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // apply the operation, update the result registers
  } ssid_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/ssid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_ctrl: operation sequencer
// Two-state machine: accept, then execute and raise the result strobe.
// ----------------------------------------------------------------------------
module ssid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output ssid_pkg::ssid_cmd_t    cmd,
  output logic                   out_valid
);
  import ssid_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.load  = start && (state_r == S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/core/ssid_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_dpath: sorted cell array and result registers
// Each cell compares the broadcast value and shifts from a neighbor.
// ----------------------------------------------------------------------------
module ssid_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire ssid_pkg::ssid_cmd_t                  cmd,
  input  wire logic [ssid_pkg::OP_W-1:0]            in_operation,
  input  wire logic signed [ssid_pkg::VAL_W-1:0]    in_value,
  input  wire logic [ssid_pkg::RANK_W-1:0]          in_rank,
  output logic [ssid_pkg::STAT_W-1:0]               out_status,
  output logic [ssid_pkg::COUNT_W-1:0]              out_count,
  output logic signed [ssid_pkg::VAL_W-1:0]         out_read_value,
  output logic                                      out_read_valid
);
  import ssid_pkg::*;

  // captured item
  op_t                     op_r;
  logic signed [VAL_W-1:0] value_r;
  logic [RANK_W-1:0]       rank_r;

  // set storage
  logic signed [VAL_W-1:0] entries_r [CAPACITY];
  logic signed [VAL_W-1:0] entries_nxt [CAPACITY];
  logic [CNT_W-1:0]        held_r, held_nxt;

  // result registers
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] rval_r, rval_nxt;
  logic                    rvalid_r, rvalid_nxt;

  logic [CAPACITY-1:0] lt;   // occupied and below the value (thermometer)
  logic [CAPACITY-1:0] eq;   // occupied and equal to the value
  logic                found;
  logic                full;
  logic                do_ins;
  logic                do_del;
  logic                rank_ok;
  logic [IDX_W-1:0]    rank_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      value_r <= in_value;
      rank_r  <= in_rank;
    end
  end

  // per-cell compare
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic occ;
    assign occ   = (CNT_W'(i) < held_r);
    assign lt[i] = occ && (entries_r[i] < value_r);
    assign eq[i] = occ && (entries_r[i] == value_r);
  end

  assign found  = |eq;
  assign full   = (held_r == CNT_W'(CAPACITY));
  assign do_ins = (op_r == OP_INSERT) && !found && !full;
  assign do_del = (op_r == OP_DELETE) && found;

  // per-cell shift: insert opens a hole at the first cell not below the
  // value, delete closes the hole at the matching cell
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] right;
    logic                    at_pos;
    if (i == 0) begin : g_first
      assign left   = value_r;
      assign at_pos = 1'b1;
    end else begin : g_mid
      assign left   = entries_r[i-1];
      assign at_pos = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = entries_r[i];
    end else begin : g_inner
      assign right = entries_r[i+1];
    end
    always_comb begin
      entries_nxt[i] = entries_r[i];
      if (do_ins && !lt[i]) begin
        entries_nxt[i] = at_pos ? value_r : left;
      end else if (do_del && !lt[i]) begin
        entries_nxt[i] = right;
      end
    end
  end

  assign rank_ok  = (32'(rank_r) < 32'(held_r));
  assign rank_idx = IDX_W'(rank_r);

  always_comb begin
    held_nxt   = held_r;
    status_nxt = ST_OK;
    rval_nxt   = '0;
    rvalid_nxt = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (found) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          held_nxt   = held_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          status_nxt = ST_DELETED;
          held_nxt   = held_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (rank_ok) begin
          rval_nxt   = entries_r[rank_idx];
          rvalid_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        held_nxt = '0;
      end
      default: begin
        held_nxt = held_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.exec) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < CAPACITY; k++) begin
        entries_r[k] <= entries_nxt[k];
      end
      status_r <= status_nxt;
      rval_r   <= rval_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_count      = COUNT_W'(held_r);
  assign out_read_value = rval_r;
  assign out_read_valid = rvalid_r;

endmodule
`default_nettype wire

FILE: rtl/core/sorted_set_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_insert_delete: ascending duplicate-free set of signed words
// Insert, delete, read by rank and clear on a shifting cell array.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start / busy         in_operation, in_value, in_rank
//  result    out_valid (strobe)   out_status, out_count, out_read_value,
//                                 out_read_valid
//
//  Every operation has a capture step that takes the item and an execute
//  step in which all cells compare against the broadcast value and shift in
//  parallel. The result strobe follows the execute cycle; a new item can be
//  taken while the strobe is high, but not while the previous item executes.
//  Reset (rst_n low at a clock edge) empties the set; cell contents are
//  left as they are. The result side has no back-pressure: out_valid is high
//  for exactly one cycle per item.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ssid_pkg::OP_W-1:0]         in_operation,
  input  wire logic signed [ssid_pkg::VAL_W-1:0] in_value,
  input  wire logic [ssid_pkg::RANK_W-1:0]       in_rank,
  output logic                                   out_valid,
  output logic [ssid_pkg::STAT_W-1:0]            out_status,
  output logic [ssid_pkg::COUNT_W-1:0]           out_count,
  output logic signed [ssid_pkg::VAL_W-1:0]      out_read_value,
  output logic                                   out_read_valid
);
  import ssid_pkg::*;

  ssid_cmd_t cmd;

  // sequencer: accept, execute, strobe
  ssid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // cell array, count and result registers
  ssid_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_rank        (in_rank),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_read_value (out_read_value),
    .out_read_valid (out_read_valid)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ssid_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssid_checker: port-level checks for the sorted set block
// Timing of transfers and consistency of result fields.
// ----------------------------------------------------------------------------
module ssid_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              out_valid,
  input  wire logic [ssid_pkg::STAT_W-1:0]       out_status,
  input  wire logic [ssid_pkg::COUNT_W-1:0]      out_count,
  input  wire logic signed [ssid_pkg::VAL_W-1:0] out_read_value,
  input  wire logic                              out_read_valid
);
  import ssid_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // an accepted item yields its result strobe after the execute state
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result strobe missing after transfer");

  // no result without an item taken before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result strobe without a transfer");

  // a read hit is only reported with status ok
  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_status == ST_OK)
    else $error("read hit with wrong status");

  // no read hit, no read data
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_value == '0)
    else $error("read data without a read hit");

  // a full report means the set held CAPACITY values (low count bits)
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_read_value (out_read_value),
  .out_read_valid (out_read_valid)
);
`default_nettype wire

FILE: tb/sorted_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_checker: result scoreboard for the sorted set block
// Keeps its own ordered copy of the set, works out the reply to every
// accepted command and compares each result strobe with the oldest reply.
// ----------------------------------------------------------------------------
module sorted_set_checker
  import ssid_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic signed [VAL_W-1:0]  in_value,
  input  wire logic [RANK_W-1:0]        in_rank,
  input  wire logic                     out_valid,
  input  wire logic [STAT_W-1:0]        out_status,
  input  wire logic [COUNT_W-1:0]       out_count,
  input  wire logic signed [VAL_W-1:0]  out_read_value,
  input  wire logic                     out_read_valid,
  output int                            mismatches,
  output int                            replies_pending
);

  typedef struct {
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [VAL_W-1:0]  value;
    logic                     valid;
  } set_reply_t;

  set_reply_t               replies_due[$];
  logic signed [VAL_W-1:0]  members [CAPACITY];
  int                       held = 0;
  int                       mismatch_count = 0;

  initial begin
    mismatches      = 0;
    replies_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("%0t sorted_set_checker: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Ordered set update; members[0 .. held-1] ascending, signed.
  task automatic apply_set_op(input op_t op, input logic signed [VAL_W-1:0] v,
                              input logic [RANK_W-1:0] rank, output set_reply_t r);
    int pos;
    bit found;
    r.status = ST_OK;
    r.value  = '0;
    r.valid  = 1'b0;
    pos = 0;
    while (pos < held && members[pos] < v) pos++;
    found = (pos < held) ? (members[pos] == v) : 1'b0;
    case (op)
      OP_INSERT: begin
        if (found) begin
          r.status = ST_DUPLICATE;
        end else if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held; i > pos; i--) members[i] = members[i-1];
          members[pos] = v;
          held++;
          r.status = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        if (found) begin
          for (int i = pos; i < held - 1; i++) members[i] = members[i+1];
          held--;
          r.status = ST_DELETED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (int'(rank) < held) begin
          r.value = members[rank];
          r.valid = 1'b1;
        end
      end
      default: held = 0;
    endcase
    r.count = COUNT_W'(held);
  endtask

  always @(posedge clk) begin : watch
    set_reply_t want;
    if (!rst_n) begin
      replies_due.delete();
      held = 0;
    end else begin
      // compare before taking a new command; a reply never lands on its own edge
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no command outstanding, status", out_status, 'x);
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_count !== want.count)
            report_mismatch("count", out_count, want.count);
          if (out_read_value !== want.value)
            report_mismatch("read_value", out_read_value, want.value);
          if (out_read_valid !== want.valid)
            report_mismatch("read_valid", out_read_valid, want.valid);
        end
      end
      if (start && !busy) begin
        apply_set_op(op_t'(in_operation), in_value, in_rank, want);
        replies_due.push_back(want);
      end
    end
    replies_pending <= replies_due.size();
    mismatches      <= mismatch_count;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_set_insert_delete
// Directed corner commands, then phases of random commands that fill, drain
// and churn the set, with random idle gaps; checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import ssid_pkg::*;

  // Worst case is roughly 480 commands, each with its transfer and the longest idle gap; keep far above.
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     start        = 1'b0;
  logic [OP_W-1:0]          in_operation = OP_READ;
  logic signed [VAL_W-1:0]  in_value     = '0;
  logic [RANK_W-1:0]        in_rank      = '0;
  logic                     busy;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [COUNT_W-1:0]       out_count;
  logic signed [VAL_W-1:0]  out_read_value;
  logic                     out_read_valid;

  int  mismatches;
  int  replies_pending;
  int  cycle_cnt = 0;
  bit  no_idle   = 1'b0;

  // Values reused across commands so duplicates and successful deletes are common.
  logic signed [VAL_W-1:0]  value_pool [POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_set_insert_delete DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_rank        (in_rank),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_read_value (out_read_value),
    .out_read_valid (out_read_valid)
  );

  sorted_set_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_read_value  (out_read_value),
    .out_read_valid  (out_read_valid),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Idle gap length: mostly back-to-back or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Command mix per phase kind: 0 fills, 1 drains, 2 churns.
  function automatic op_t pick_op(input int kind);
    int r;
    int ins_w;
    int del_w;
    int rd_w;
    r = $urandom_range(0, 99);
    case (kind)
      0:       begin ins_w = 70; del_w = 10; rd_w = 17; end
      1:       begin ins_w = 20; del_w = 55; rd_w = 20; end
      default: begin ins_w = 40; del_w = 30; rd_w = 25; end
    endcase
    if (r < ins_w) return OP_INSERT;
    if (r < ins_w + del_w) return OP_DELETE;
    if (r < ins_w + del_w + rd_w) return OP_READ;
    return OP_CLEAR;
  endfunction

  // Mostly pool values, some signed extremes, the rest fully random words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    logic signed [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (r < 65) begin
      case ($urandom_range(0, 5))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh8000_0001;
        2:       v = 32'sh7fff_ffff;
        3:       v = -32'sd1;
        4:       v = 32'sd1;
        default: v = 32'sd0;
      endcase
    end else begin
      v = $urandom;
      // refresh the pool slowly so its contents drift over the run
      if ($urandom_range(0, 4) == 0) value_pool[$urandom_range(0, POOL_SIZE - 1)] = v;
    end
    return v;
  endfunction

  // One command transfer: hold start until an edge sees busy low, then idle.
  task automatic send(input op_t op, input logic signed [VAL_W-1:0] v,
                      input logic [RANK_W-1:0] r);
    int gap;
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    in_rank      <= r;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      // start low; payload carries junk the block must ignore
      start        <= 1'b0;
      in_operation <= OP_W'($urandom);
      in_value     <= $urandom;
      in_rank      <= RANK_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int kind;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // empty set: delete misses, read gives nothing
    send(OP_DELETE, 32'sd5, 4'd0);
    send(OP_READ, 32'sd0, 4'd0);
    // signed extremes land in order; repeated zero is a duplicate
    send(OP_INSERT, 32'sh7fff_ffff, 4'd0);
    send(OP_INSERT, 32'sh8000_0000, 4'd0);
    send(OP_INSERT, 32'sd0, 4'd0);
    send(OP_INSERT, -32'sd1, 4'd0);
    send(OP_INSERT, 32'sd0, 4'd0);
    send(OP_READ, 32'sd0, 4'd0);
    send(OP_READ, 32'sd0, 4'd3);
    // miss, then remove the top element
    send(OP_DELETE, 32'sd5, 4'd0);
    send(OP_DELETE, 32'sh7fff_ffff, 4'd0);
    // fill to capacity from three held values
    for (int i = 1; i <= CAPACITY - 3; i++) send(OP_INSERT, i * 1000 + 7, 4'd0);
    // full set: new value is dropped, a held one is still a duplicate
    send(OP_INSERT, 32'sd123457, 4'd0);
    send(OP_INSERT, -32'sd1, 4'd0);
    send(OP_READ, 32'sd0, 4'd15);
    send(OP_DELETE, 32'sh8000_0000, 4'd0);
    send(OP_CLEAR, 32'sd0, 4'd0);
    send(OP_READ, 32'sd0, 4'd0);

    // --- random phases; two of them run without idle gaps ---
    for (int p = 0; p < 9; p++) begin
      kind    = p % 3;
      no_idle = (p == 3) || (p == 7);
      repeat (50) send(pick_op(kind), pick_value(), RANK_W'($urandom_range(0, 15)));
    end
    no_idle = 1'b0;

    start <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    // a few more cycles to catch stray strobes
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ssid_pkg.sv
rtl/core/ssid_ctrl.sv
rtl/core/ssid_dpath.sv
rtl/core/sorted_set_insert_delete.sv
rtl/core/ssid_checker.sv
tb/sorted_set_checker.sv
tb/tb_top.sv
